// File: rtl/psbp_pkg.sv
// psbp_pkg: shared constants, types and the ink placement function for the
// pixel screen byte packer. No dependencies.
`timescale 1ns / 1ps
package psbp_pkg;

	localparam int BYTES_PER_LINE = 80;
	localparam int LINES          = 200;
	localparam int BANK_STRIDE    = 2048;

	localparam int MODE_W   = 2;
	localparam int WIDTH_W  = 10;
	localparam int INK_W    = 4;
	localparam int ADDR_W   = 14;
	localparam int BYTE_W   = 8;
	localparam int COL_W    = 10;
	localparam int ROW_W    = 8;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 10;

	typedef enum logic [MODE_W-1:0] {
		MODE_NIBBLE = 2'd0,
		MODE_PAIR   = 2'd1,
		MODE_BIT    = 2'd2,
		MODE_SPARE  = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCREEN_MODE = 1'b0,
		REG_IMAGE_WIDTH = 1'b1
	} cfg_reg_t;

	// ink bits placed into byte position for one pixel slot
	function automatic logic [BYTE_W-1:0] place_ink(input mode_t mode,
		input logic [2:0] slot, input logic [INK_W-1:0] ink);
		logic [BYTE_W-1:0] v;
		v = '0;
		case (mode)
			MODE_NIBBLE: begin
				if (slot[0] == 1'b0) begin
					v[7] = ink[0];
					v[3] = ink[1];
					v[5] = ink[2];
					v[1] = ink[3];
				end else begin
					v[6] = ink[0];
					v[2] = ink[1];
					v[4] = ink[2];
					v[0] = ink[3];
				end
			end
			MODE_PAIR: begin
				v[3'd7 - {1'b0, slot[1:0]}] = ink[0];
				v[3'd3 - {1'b0, slot[1:0]}] = ink[1];
			end
			default: begin
				v[3'd7 - slot] = ink[0];
			end
		endcase
		return v;
	endfunction

endpackage

// File: rtl/pixel_screen_byte_packer_top.sv
// pixel_screen_byte_packer_top: packs a raster stream of ink indices into
// interleaved display memory bytes. Depends on psbp_pkg.
`timescale 1ns / 1ps
// One pixel word is taken per clock. The row/column counters and the partially
// gathered byte are the input-side state; a short path (bit placement mux, a
// constant multiply by the line pitch and an add) produces the finished byte,
// which lands in a single output register. Throughput is one pixel per cycle,
// and a finished byte appears on the output in the cycle after the pixel that
// completes it. The input stalls only while the output register holds a byte
// that the downstream side is stalling; pixels that finish no byte still need
// that register free. Mode 0 packs two 4-bit pixels per byte in scrambled bit
// order, mode 1 four 2-bit pixels, mode 2 (and the spare code 3) eight 1-bit
// pixels. A row ending inside a byte flushes that byte zero padded; pixels
// past the display line are dropped. Configuration must be written while idle.
module pixel_screen_byte_packer_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [psbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [psbp_pkg::CFG_DAT_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [psbp_pkg::INK_W-1:0]      ink,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [psbp_pkg::ADDR_W-1:0]     screen_address,
	output logic [psbp_pkg::BYTE_W-1:0]     screen_byte
);
	import psbp_pkg::*;

	localparam logic [ADDR_W-1:0] BPL_C    = ADDR_W'(BYTES_PER_LINE);
	localparam logic [ADDR_W-1:0] STRIDE_C = ADDR_W'(BANK_STRIDE);
	localparam logic [ROW_W:0]    LINES_C  = (ROW_W+1)'(LINES);

	// configuration registers
	logic [MODE_W-1:0]  screen_mode_q;
	logic [WIDTH_W-1:0] image_width_q;

	// raster state
	logic [COL_W-1:0]  column_q;
	logic [ROW_W-1:0]  row_q;
	logic [BYTE_W-1:0] partial_q;

	// output register
	logic              out_valid_q;
	logic [ADDR_W-1:0] addr_q;
	logic [BYTE_W-1:0] byte_q;

	mode_t             mode;
	logic [2:0]        slot;
	logic [COL_W-1:0]  xb;
	logic              last_slot;
	logic              in_line;
	logic              row_end;
	logic              accept;
	logic              emit;
	logic [BYTE_W-1:0] gathered;
	logic [ADDR_W-1:0] addr_calc;
	logic [ROW_W:0]    row_inc;

	// spare mode code behaves as one-bit pixels
	always_comb begin
		mode = (mode_t'(screen_mode_q) == MODE_SPARE) ? MODE_BIT : mode_t'(screen_mode_q);
	end

	// slot inside the byte and byte column for the current mode
	always_comb begin
		case (mode)
			MODE_NIBBLE: begin
				slot      = {2'b00, column_q[0]};
				xb        = {1'b0, column_q[COL_W-1:1]};
				last_slot = (column_q[0] == 1'b1);
			end
			MODE_PAIR: begin
				slot      = {1'b0, column_q[1:0]};
				xb        = {2'b00, column_q[COL_W-1:2]};
				last_slot = (column_q[1:0] == 2'b11);
			end
			default: begin
				slot      = column_q[2:0];
				xb        = {3'b000, column_q[COL_W-1:3]};
				last_slot = (column_q[2:0] == 3'b111);
			end
		endcase
	end

	assign in_line = (xb < COL_W'(BYTES_PER_LINE));
	// width 0 acts as width 1: the compare is then always true
	assign row_end = ({1'b0, column_q} + 11'd1) >= {1'b0, image_width_q};

	// fresh byte at slot 0, so stale bits never leak across mode changes
	assign gathered = ((slot == 3'd0) ? '0 : partial_q) | place_ink(mode, slot, ink);

	// interleaved address: eight banks of 2048 bytes, text rows one line pitch apart in a bank
	assign addr_calc = ADDR_W'({3'b000, row_q[ROW_W-1:3]}) * BPL_C
		+ ADDR_W'(row_q[2:0]) * STRIDE_C
		+ ADDR_W'(xb);

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;
	assign emit     = accept & in_line & (last_slot | row_end);
	assign row_inc  = {1'b0, row_q} + 9'd1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_mode_q <= MODE_W'(MODE_NIBBLE);
			image_width_q <= WIDTH_W'(160);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_SCREEN_MODE: screen_mode_q <= cfg_data[MODE_W-1:0];
				REG_IMAGE_WIDTH: image_width_q <= cfg_data[WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	// raster counters and gathered bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q  <= '0;
			row_q     <= '0;
			partial_q <= '0;
		end else if (accept) begin
			if (in_line) begin
				partial_q <= (last_slot | row_end) ? '0 : gathered;
			end
			if (row_end) begin
				column_q <= '0;
				row_q    <= (row_inc >= LINES_C) ? '0 : row_inc[ROW_W-1:0];
			end else begin
				column_q <= column_q + COL_W'(1);
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			addr_q <= addr_calc;
			byte_q <= gathered;
		end
	end

	assign out_valid      = out_valid_q;
	assign screen_address = addr_q;
	assign screen_byte    = byte_q;

`ifndef SYNTH
	// a completed byte shows up in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n) emit |=> out_valid_q)
		else $error("completed word not presented");

	// row counter never reaches the line count
	assert property (@(posedge clk) disable iff (!arst_n) {1'b0, row_q} < LINES_C)
		else $error("row counter out of range");

	// a pixel that ends a row leaves the next one at column zero
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && row_end |=> column_q == '0)
		else $error("column not cleared at row end");

	// a row end inside the line always flushes a word
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && row_end && in_line |-> emit)
		else $error("row end did not flush word");
`endif

endmodule
